/* rtl/g2h_pkg.sv */
`default_nettype none

package g2h_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YY_W    = 14;   // shifted year, up to 8895
    localparam int SINCE_W = 21;   // days since epoch, up to about 1.27M
    localparam int CYCLE_W = 8;
    localparam int REST_W  = 14;   // day within a 30-year cycle
    localparam int YIN_W   = 5;    // year within cycle, 0..29
    localparam int DOY_W   = 9;    // day of year, below 512
    localparam int MOFS_W  = 9;    // month offset term of the day number formula
    localparam int MCNT_W  = 4;    // months walked, 0..12

    localparam int EPOCH_JDN     = 1948439;
    localparam int CYCLE_DAYS    = 10631;
    localparam int CYCLE_YEARS   = 30;
    localparam int JDN_OFFSET    = 32045;
    localparam int YEAR_SHIFT    = 4800;
    localparam int FX_SCALE      = 100000;
    localparam int FX_MEAN_YEAR  = 35436667;
    localparam int FX_FIT_OFFSET = 13350;
    localparam int FX_HALF       = 50000;
    localparam int MONTHS        = 12;
    localparam int MONTH_COUNT   = 16;  // every code of the month field

    // floor(x / 100) = (x * 5243) >> 19 for x below 2^14
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          DIV100_W     = 7;
    localparam int          DIV400_W     = 5;

    // floor(x / 10631) = (x * 3232033) >> 35 for x below 2^21
    localparam logic [21:0] CYCLE_RECIP = 22'd3232033;
    localparam int          CYCLE_SHIFT = 35;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [SINCE_W-1:0] since_t;
    typedef logic [CYCLE_W-1:0] cycle_t;
    typedef logic [REST_W-1:0]  rest_t;
    typedef logic [YIN_W-1:0]   yin_t;
    typedef logic [DOY_W-1:0]   doy_t;
    typedef logic [MOFS_W-1:0]  mofs_t;
    typedef logic [MCNT_W-1:0]  mcnt_t;

    typedef rest_t rest_tbl_t [CYCLE_YEARS];
    typedef doy_t  doy_tbl_t  [MONTHS+1];
    typedef mofs_t mofs_tbl_t [MONTH_COUNT];

    // months alternate 30 and 29 days
    function automatic doy_tbl_t month_start_tbl();
        doy_tbl_t tbl;
        for (int k = 0; k <= MONTHS; k++) begin
            tbl[k] = DOY_W'(29 * k + (k + 1) / 2);
        end
        return tbl;
    endfunction

    // first day within the cycle at which the year estimate reaches j:
    // ceil((j * 35436667 + 13350) / 100000)
    localparam rest_tbl_t YEAR_START = '{
        14'd1,    14'd355,  14'd709,  14'd1064, 14'd1418, 14'd1772, 14'd2127, 14'd2481,
        14'd2836, 14'd3190, 14'd3544, 14'd3899, 14'd4253, 14'd4607, 14'd4962, 14'd5316,
        14'd5671, 14'd6025, 14'd6379, 14'd6734, 14'd7088, 14'd7442, 14'd7797, 14'd8151,
        14'd8505, 14'd8860, 14'd9214, 14'd9569, 14'd9923, 14'd10277
    };

    // rounded day count of j mean years: floor((j * 35436667 + 50000) / 100000)
    localparam rest_tbl_t YEAR_BASE = '{
        14'd0,    14'd354,  14'd709,  14'd1063, 14'd1417, 14'd1772, 14'd2126, 14'd2481,
        14'd2835, 14'd3189, 14'd3544, 14'd3898, 14'd4252, 14'd4607, 14'd4961, 14'd5316,
        14'd5670, 14'd6024, 14'd6379, 14'd6733, 14'd7087, 14'd7442, 14'd7796, 14'd8150,
        14'd8505, 14'd8859, 14'd9214, 14'd9568, 14'd9922, 14'd10277
    };

    localparam doy_tbl_t  MONTH_START  = month_start_tbl();

    // (153*mm + 2) / 5 with march-based month, borrowing for month up to 2
    localparam mofs_tbl_t MONTH_OFFSET = '{
        9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
    };

endpackage

`default_nettype wire

/* rtl/g2h_day_count.sv */
`default_nettype none

module g2h_day_count import g2h_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   en,
    input  wire year_t  greg_year,
    input  wire month_t greg_month,
    input  wire day_t   greg_day,
    output since_t      since
);

    logic [YY_W-1:0]       yy;
    logic [YY_W-3:0]       yy_q4;
    logic [26:0]           d100_prod;
    logic [24:0]           d400_prod;
    logic [DIV100_W-1:0]   yy_d100;
    logic [DIV400_W-1:0]   yy_d400;
    logic [22:0]           yy_x365;
    logic [21:0]           pos_sum;
    logic [21:0]           neg_sum;
    since_t                since_next;
    since_t                since_reg;

    always_comb begin
        yy = YY_W'(greg_year) + YY_W'(YEAR_SHIFT)
             - ((greg_month <= month_t'(2)) ? YY_W'(1) : YY_W'(0));
        yy_q4     = yy[YY_W-1:2];
        d100_prod = 27'(yy) * 27'(DIV100_RECIP);
        d400_prod = 25'(yy_q4) * 25'(DIV100_RECIP);
        yy_d100   = d100_prod[DIV100_SHIFT +: DIV100_W];
        // floor(yy/400) = floor(floor(yy/4)/100)
        yy_d400   = d400_prod[DIV100_SHIFT +: DIV400_W];
        yy_x365   = 23'(yy) * 23'd365;
        pos_sum   = yy_x365[21:0] + 22'(yy_q4) + 22'(yy_d400)
                    + 22'(MONTH_OFFSET[greg_month]) + 22'(greg_day);
        neg_sum   = 22'(yy_d100) + 22'(JDN_OFFSET + EPOCH_JDN);
        // dates before the epoch saturate to day zero
        since_next = (pos_sum >= neg_sum) ? SINCE_W'(pos_sum - neg_sum) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            since_reg <= since_next;
        end
    end

    assign since = since_reg;

endmodule

`default_nettype wire

/* rtl/g2h_cycle_split.sv */
`default_nettype none

module g2h_cycle_split import g2h_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   en_div,
    input  wire logic   en_rem,
    input  wire since_t since,
    output cycle_t      cycles,
    output rest_t       rest
);

    logic [42:0]  recip_prod;
    cycle_t       cycles_next;
    cycle_t       cycles_reg;
    since_t       since_reg;
    logic [20:0]  cyc_days;
    rest_t        rest_next;
    rest_t        rest_reg;
    cycle_t       cycles_out_reg;

    always_comb begin
        recip_prod  = 43'(since) * 43'(CYCLE_RECIP);
        cycles_next = recip_prod[CYCLE_SHIFT +: CYCLE_W];
    end

    always_ff @(posedge aclk) begin
        if (en_div) begin
            cycles_reg <= cycles_next;
            since_reg  <= since;
        end
    end

    always_comb begin
        cyc_days  = 21'(cycles_reg) * 21'(CYCLE_DAYS);
        rest_next = REST_W'(since_reg - cyc_days);
    end

    always_ff @(posedge aclk) begin
        if (en_rem) begin
            rest_reg       <= rest_next;
            cycles_out_reg <= cycles_reg;
        end
    end

    assign cycles = cycles_out_reg;
    assign rest   = rest_reg;

endmodule

`default_nettype wire

/* rtl/g2h_year_fit.sv */
`default_nettype none

module g2h_year_fit import g2h_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   en,
    input  wire cycle_t cycles,
    input  wire rest_t  rest,
    output year_t       year,
    output doy_t        doy
);

    yin_t   yin;
    rest_t  base;
    year_t  year_next;
    doy_t   doy_next;
    year_t  year_reg;
    doy_t   doy_reg;

    always_comb begin
        // thresholds rise with j, so the last one passed gives the year
        yin = '0;
        for (int j = 1; j < CYCLE_YEARS; j++) begin
            if (rest >= YEAR_START[j]) begin
                yin = YIN_W'(j);
            end
        end
        base      = YEAR_BASE[yin];
        year_next = YEAR_W'(16'(cycles) * 16'(CYCLE_YEARS) + 16'(yin) + 16'd1);
        doy_next  = (rest >= base) ? DOY_W'(rest - base) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            year_reg <= year_next;
            doy_reg  <= doy_next;
        end
    end

    assign year = year_reg;
    assign doy  = doy_reg;

endmodule

`default_nettype wire

/* rtl/g2h_month_walk.sv */
`default_nettype none

module g2h_month_walk import g2h_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire year_t year,
    input  wire doy_t  doy,
    output year_t      hijri_year,
    output month_t     hijri_month,
    output day_t       hijri_day
);

    mcnt_t  walked;
    doy_t   day_full;
    month_t month_next;
    day_t   day_next;
    year_t  year_reg;
    month_t month_reg;
    day_t   day_reg;

    always_comb begin
        walked = '0;
        for (int k = 1; k <= MONTHS; k++) begin
            if (doy >= MONTH_START[k]) begin
                walked = MCNT_W'(k);
            end
        end
        day_full = doy + DOY_W'(1) - MONTH_START[walked];
        day_next = day_full[DAY_W-1:0];
        // a walk past the last month stays in the last month
        month_next = (walked == MCNT_W'(MONTHS)) ? MONTH_W'(MONTHS)
                                                  : MONTH_W'(walked + MCNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            year_reg  <= year;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign hijri_year  = year_reg;
    assign hijri_month = month_reg;
    assign hijri_day   = day_reg;

endmodule

`default_nettype wire

/* rtl/gregorian_to_tabular_hijri_unit.sv */
// one register per stage: input, day count, divide, remainder, year fit, month walk
// throughput: one date per cycle unless stalled; the six-stage pipeline holds up to six dates
// a stalled stage holds its date while empty stages behind it keep filling
// reset: synchronous, active low, empties every stage; data registers are not reset
`default_nettype none

module gregorian_to_tabular_hijri_unit import g2h_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire year_t  s_greg_year,
    input  wire month_t s_greg_month,
    input  wire day_t   s_greg_day,
    output logic        m_valid,
    input  wire logic   m_ready,
    output year_t       m_hijri_year,
    output month_t      m_hijri_month,
    output day_t        m_hijri_day
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] en;

    year_t  yr_reg;
    month_t mo_reg;
    day_t   dy_reg;

    since_t since;
    cycle_t cycles;
    rest_t  rest;
    year_t  year;
    doy_t   doy;

    // a stage can take new data when it is empty or its content moves on
    always_comb begin
        adv[STAGES-1] = m_ready || !vld_reg[STAGES-1];
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = adv[i+1] || !vld_reg[i];
        end
        en[0]       = s_valid && adv[0];
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            en[i]       = adv[i] && vld_reg[i-1];
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            yr_reg <= s_greg_year;
            mo_reg <= s_greg_month;
            dy_reg <= s_greg_day;
        end
    end

    g2h_day_count u_day_count (
        .aclk       (aclk),
        .en         (en[1]),
        .greg_year  (yr_reg),
        .greg_month (mo_reg),
        .greg_day   (dy_reg),
        .since      (since)
    );

    g2h_cycle_split u_cycle_split (
        .aclk   (aclk),
        .en_div (en[2]),
        .en_rem (en[3]),
        .since  (since),
        .cycles (cycles),
        .rest   (rest)
    );

    g2h_year_fit u_year_fit (
        .aclk   (aclk),
        .en     (en[4]),
        .cycles (cycles),
        .rest   (rest),
        .year   (year),
        .doy    (doy)
    );

    g2h_month_walk u_month_walk (
        .aclk        (aclk),
        .en          (en[5]),
        .year        (year),
        .doy         (doy),
        .hijri_year  (m_hijri_year),
        .hijri_month (m_hijri_month),
        .hijri_day   (m_hijri_day)
    );

    // no transfer is taken while reset is held
    assign s_ready = adv[0] && aresetn;
    assign m_valid = vld_reg[STAGES-1];

endmodule

`default_nettype wire

/* tb/g2h_checker.sv */
`default_nettype none

module hijri_date_checker import g2h_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    input  wire logic   s_ready,
    input  wire year_t  s_greg_year,
    input  wire month_t s_greg_month,
    input  wire day_t   s_greg_day,
    input  wire logic   m_valid,
    input  wire logic   m_ready,
    input  wire year_t  m_hijri_year,
    input  wire month_t m_hijri_month,
    input  wire day_t   m_hijri_day,
    output int          errors,
    output int          outstanding,
    output int          checked,
    output int          clamped_walks,
    output int          pre_epoch
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
    } hijri_t;

    hijri_t hijri_due [$];

    initial begin
        errors        = 0;
        outstanding   = 0;
        checked       = 0;
        clamped_walks = 0;
        pre_epoch     = 0;
    end

    // julian day number, 30-year cycles, fixed-point year estimate, month walk
    function automatic hijri_t to_hijri(input year_t gy, input month_t gm, input day_t gd,
                                        output bit walk_clamped, output bit early);
        hijri_t res;
        longint borrow, yy, mm, jdn, since, cyc, rest, numer, yin, doy, mon, dd, len;
        borrow = (gm <= 2) ? 1 : 0;
        yy     = longint'(gy) + YEAR_SHIFT - borrow;
        mm     = longint'(gm) + 12 * borrow - 3;
        jdn    = longint'(gd) + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400
                 - JDN_OFFSET;
        since  = jdn - EPOCH_JDN;
        early  = since < 0;
        if (early) begin
            since = 0;
        end
        cyc   = since / CYCLE_DAYS;
        rest  = since % CYCLE_DAYS;
        numer = rest * FX_SCALE - FX_FIT_OFFSET;
        yin   = (numer < 0) ? 0 : numer / FX_MEAN_YEAR;
        doy   = rest - (yin * FX_MEAN_YEAR + FX_HALF) / FX_SCALE;
        if (doy < 0) begin
            doy = 0;
        end
        mon = 1;
        dd  = doy + 1;
        for (int k = 0; k < MONTHS; k++) begin
            len = (k % 2 == 0) ? 30 : 29;
            if (dd > len) begin
                dd  -= len;
                mon += 1;
            end else begin
                break;
            end
        end
        walk_clamped = mon > MONTHS;
        if (walk_clamped) begin
            mon = MONTHS;
        end
        res.year  = year_t'(1 + yin + CYCLE_YEARS * cyc);
        res.month = month_t'(mon);
        res.day   = day_t'(dd);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        hijri_t want;
        bit     clamp, early;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                hijri_due.push_back(to_hijri(s_greg_year, s_greg_month, s_greg_day,
                                             clamp, early));
                clamped_walks += int'(clamp);
                pre_epoch     += int'(early);
            end
            if (m_valid && m_ready) begin
                if (hijri_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with none expected",
                                              m_hijri_year, m_hijri_month, m_hijri_day));
                end else begin
                    want = hijri_due.pop_front();
                    if (m_hijri_year !== want.year) begin
                        report_mismatch($sformatf("result %0d year %0d, expected %0d",
                                                  checked, m_hijri_year, want.year));
                    end
                    if (m_hijri_month !== want.month) begin
                        report_mismatch($sformatf("result %0d month %0d, expected %0d",
                                                  checked, m_hijri_month, want.month));
                    end
                    if (m_hijri_day !== want.day) begin
                        report_mismatch($sformatf("result %0d day %0d, expected %0d",
                                                  checked, m_hijri_day, want.day));
                    end
                end
                checked++;
            end
        end
        outstanding <= hijri_due.size();
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import g2h_pkg::*;

    localparam int RANDOM_DATES = 2000;
    localparam int CYCLE_LIMIT  = 300000;

    logic   aclk          = 1'b0;
    logic   aresetn       = 1'b0;
    logic   s_valid       = 1'b0;
    logic   s_ready;
    year_t  s_greg_year   = '0;
    month_t s_greg_month  = '0;
    day_t   s_greg_day    = '0;
    logic   m_valid;
    logic   m_ready       = 1'b0;
    year_t  m_hijri_year;
    month_t m_hijri_month;
    day_t   m_hijri_day;

    int errors, outstanding, checked, clamped_walks, pre_epoch;
    int cycles = 0;
    int sent   = 0;
    bit calm   = 1'b0;

    // extremes, out-of-range month and day codes, dates around the epoch
    // and a date whose month walk runs past the twelfth month
    int directed [22][3] = '{
        '{700, 1, 1},   '{4095, 12, 31}, '{0, 0, 0},      '{622, 7, 17},
        '{622, 7, 18},  '{623, 7, 7},    '{623, 7, 8},    '{4095, 15, 31},
        '{2000, 0, 15}, '{2000, 13, 1},  '{2000, 14, 10}, '{2000, 15, 31},
        '{2023, 3, 0},  '{2023, 2, 31},  '{2024, 2, 29},  '{1900, 3, 1},
        '{2000, 2, 29}, '{2100, 3, 1},   '{1582, 10, 15}, '{2730, 5, 21},
        '{4095, 0, 0},  '{1365, 10, 10}
    };

    gregorian_to_tabular_hijri_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_greg_year   (s_greg_year),
        .s_greg_month  (s_greg_month),
        .s_greg_day    (s_greg_day),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hijri_year  (m_hijri_year),
        .m_hijri_month (m_hijri_month),
        .m_hijri_day   (m_hijri_day)
    );

    hijri_date_checker hijri_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_greg_year   (s_greg_year),
        .s_greg_month  (s_greg_month),
        .s_greg_day    (s_greg_day),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hijri_year  (m_hijri_year),
        .m_hijri_month (m_hijri_month),
        .m_hijri_day   (m_hijri_day),
        .errors        (errors),
        .outstanding   (outstanding),
        .checked       (checked),
        .clamped_walks (clamped_walks),
        .pre_epoch     (pre_epoch)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int days_in_month(input int y, input int mo);
        if (mo == 2) begin
            return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
        end
        return (mo == 4 || mo == 6 || mo == 9 || mo == 11) ? 30 : 31;
    endfunction

    task automatic send_date(input int y, input int mo, input int d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_greg_year  <= year_t'(y);
        s_greg_month <= month_t'(mo);
        s_greg_day   <= day_t'(d);
        do @(posedge aclk); while (!(s_valid && s_ready));
        sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // result side: random stall before each transfer
    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        int n_random, y, mo, d, pick, run_len;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_date(directed[i][0], directed[i][1], directed[i][2]);
        end
        wait_drained();

        n_random = 0;
        while (n_random < RANDOM_DATES) begin
            if (n_random % 150 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n_random == RANDOM_DATES / 2) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                // run of consecutive days, which can cross hijri month and year boundaries
                y       = $urandom_range(700, 4095);
                mo      = $urandom_range(1, 12);
                d       = $urandom_range(1, days_in_month(y, mo));
                run_len = $urandom_range(10, 40);
                for (int k = 0; k < run_len; k++) begin
                    send_date(y, mo, d);
                    d++;
                    if (d > days_in_month(y, mo)) begin
                        d = 1;
                        if (mo == 12) begin
                            mo = 1;
                            y  = (y == 4095) ? 700 : y + 1;
                        end else begin
                            mo++;
                        end
                    end
                end
                n_random += run_len;
            end else begin
                if (pick < 75) begin
                    y  = $urandom_range(700, 4095);
                    mo = $urandom_range(1, 12);
                    d  = $urandom_range(1, days_in_month(y, mo));
                end else if (pick < 88) begin
                    // any year, including ones before the epoch
                    y  = $urandom_range(0, 4095);
                    mo = $urandom_range(1, 12);
                    d  = $urandom_range(1, days_in_month(y, mo));
                end else begin
                    y  = $urandom_range(0, 4095);
                    mo = $urandom_range(0, 15);
                    d  = $urandom_range(0, 31);
                end
                send_date(y, mo, d);
                n_random++;
            end
        end

        wait_drained();
        repeat (12) @(posedge aclk);

        $display("%0d dates converted (%0d directed), %0d results checked", sent,
                 $size(directed), checked);
        $display("%0d dates before the epoch, %0d month walks past the twelfth month",
                 pre_epoch, clamped_walks);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
